// ----- rtl/grain128a_key_filter_unit_macros.svh -----
// Assertion macros used by the checker file of the key filter unit.
`ifndef GRAIN128A_KEY_FILTER_UNIT_MACROS_SVH
`define GRAIN128A_KEY_FILTER_UNIT_MACROS_SVH

// Overlapping implication on the same edge, disabled during reset.
`define G128KF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked on the following edge, disabled during reset.
`define G128KF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/g128kf_pkg.sv -----
// Shared constants and types of the Grain-128a key filter unit.
package g128kf_pkg;

    localparam int DEFAULT_MAX_CHECKS  = 4;
    localparam int DEFAULT_OFFSET_BITS = 8;

    localparam int KEY_HALF_W   = 64;
    localparam int IV_LOW_W     = 64;
    localparam int IV_HIGH_W    = 32;
    localparam int REG_LEN      = 128;
    localparam int INIT_ROUNDS  = 256;
    localparam int ROUND_W      = $clog2(INIT_ROUNDS);
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_COUNT_W  = 3;
    localparam int CHECK_W      = 16;
    localparam int CHECK_REGS_MAX = 4;
    localparam int BYTE_W       = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IV_LOW      = 3'd0,
        CFG_IV_HIGH     = 3'd1,
        CFG_CHECK_COUNT = 3'd2,
        CFG_CHECK_0     = 3'd3,
        CFG_CHECK_1     = 3'd4,
        CFG_CHECK_2     = 3'd5,
        CFG_CHECK_3     = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_INIT   = 4'b0010,
        S_STREAM = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init_step;
        logic stream_step;
        logic byte_end;
        logic capture;
    } dp_cmd_t;

endpackage

// ----- rtl/g128kf_if.sv -----
// Channel interfaces: key input, result output and configuration write.
interface g128kf_key_if;
    import g128kf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [KEY_HALF_W-1:0] key_low;
    logic [KEY_HALF_W-1:0] key_high;
    modport source (output valid, output key_low, output key_high, input ready);
    modport sink (input valid, input key_low, input key_high, output ready);
endinterface

interface g128kf_result_if;
    logic valid;
    logic ready;
    logic key_passes;
    modport source (output valid, output key_passes, input ready);
    modport sink (input valid, input key_passes, output ready);
endinterface

interface g128kf_cfg_if;
    import g128kf_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/g128kf_ctrl.sv -----
// Sequencer: load, initialization rounds, keystream bytes and result hand-off.
module g128kf_ctrl
    import g128kf_pkg::*;
#(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dp_cmd_t                cmd,
    output logic [OFFSET_BITS-1:0] byte_offset
);

    localparam int STREAM_W = OFFSET_BITS + 3;

    state_t               state_reg, state_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic [STREAM_W-1:0]  stream_reg, stream_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 slot_free;

    assign slot_free   = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign byte_offset = stream_reg[STREAM_W-1:3];

    always_comb
    begin
        state_next      = state_reg;
        round_next      = round_reg;
        stream_next     = stream_reg;
        out_valid_next  = out_valid_reg;
        cmd             = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    round_next = '0;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                round_next    = round_reg + 1'b1;
                if (round_reg == {ROUND_W{1'b1}})
                begin
                    stream_next = '0;
                    state_next  = S_STREAM;
                end
            end
            S_STREAM:
            begin
                cmd.stream_step = 1'b1;
                cmd.byte_end    = (stream_reg[2:0] == 3'b111);
                stream_next     = stream_reg + 1'b1;
                if (stream_reg == {STREAM_W{1'b1}})
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // The result register frees up in the same cycle it is read.
                if (slot_free)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            stream_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            stream_reg    <= stream_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/g128kf_datapath.sv -----
// Cipher state, configuration registers, keystream byte checks and result.
module g128kf_datapath
    import g128kf_pkg::*;
#(
    parameter int MAX_CHECKS  = DEFAULT_MAX_CHECKS,
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    input  logic [OFFSET_BITS-1:0] byte_offset,
    input  logic [KEY_HALF_W-1:0]  key_low,
    input  logic [KEY_HALF_W-1:0]  key_high,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   key_passes
);

    localparam int NUM_CHECK_REGS = (MAX_CHECKS < CHECK_REGS_MAX) ? MAX_CHECKS : CHECK_REGS_MAX;
    localparam int CHK_IDX_W      = $clog2(MAX_CHECKS + 1);
    localparam int CMP_W          = 5;

    logic [IV_LOW_W-1:0]    iv_low_reg;
    logic [IV_HIGH_W-1:0]   iv_high_reg;
    logic [CFG_COUNT_W-1:0] count_reg;
    logic [CHECK_W-1:0]     check_reg [NUM_CHECK_REGS];
    logic [CHECK_W-1:0]     check_sel [MAX_CHECKS];

    logic [REG_LEN-1:0]   nfsr_reg, nfsr_next;
    logic [REG_LEN-1:0]   lfsr_reg, lfsr_next;
    logic [BYTE_W-1:0]    byte_shift_reg, byte_shift_next;
    logic [CHK_IDX_W-1:0] check_index_reg, check_index_next;
    logic                 mismatch_reg, mismatch_next;
    logic                 result_reg;

    logic                 z, lf, nf, feed;
    logic [BYTE_W-1:0]    new_byte;
    logic [CHECK_W-1:0]   cur_check;
    logic [OFFSET_BITS+BYTE_W-1:0] offset_ext;
    logic [OFFSET_BITS-1:0] check_offset;
    logic [CMP_W-1:0]     count_ext, count_lim, count_eff, index_ext;
    logic                 pending;

    // Configuration registers; writes to unknown indexes fall through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_low_reg  <= '0;
            iv_high_reg <= '0;
            count_reg   <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_IV_LOW)
            begin
                iv_low_reg <= cfg_data;
            end
            if (cfg_index == CFG_IV_HIGH)
            begin
                iv_high_reg <= cfg_data[IV_HIGH_W-1:0];
            end
            if (cfg_index == CFG_CHECK_COUNT)
            begin
                count_reg <= cfg_data[CFG_COUNT_W-1:0];
            end
        end
    end

    for (genvar g = 0; g < NUM_CHECK_REGS; g++)
    begin : g_check
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                check_reg[g] <= '0;
            end
            else if (cfg_write && (cfg_index == CFG_INDEX_W'(int'(CFG_CHECK_0) + g)))
            begin
                check_reg[g] <= cfg_data[CHECK_W-1:0];
            end
        end
    end

    // Checks beyond the writable registers keep their reset value of zero.
    for (genvar g = 0; g < MAX_CHECKS; g++)
    begin : g_sel
        if (g < NUM_CHECK_REGS)
        begin : g_real
            assign check_sel[g] = check_reg[g];
        end
        else
        begin : g_zero
            assign check_sel[g] = '0;
        end
    end

    always_comb
    begin
        cur_check = '0;
        for (int i = 0; i < MAX_CHECKS; i++)
        begin
            if (check_index_reg == CHK_IDX_W'(i))
            begin
                cur_check = check_sel[i];
            end
        end
    end

    assign offset_ext   = {{OFFSET_BITS{1'b0}}, cur_check[CHECK_W-1:BYTE_W]};
    assign check_offset = offset_ext[OFFSET_BITS-1:0];
    assign count_ext    = CMP_W'(count_reg);
    assign count_lim    = CMP_W'(MAX_CHECKS);
    assign count_eff    = (count_ext > count_lim) ? count_lim : count_ext;
    assign index_ext    = CMP_W'(check_index_reg);
    assign pending      = (index_ext < count_eff);

    // Pre-output and feedback functions of Grain-128a.
    always_comb
    begin
        z = (nfsr_reg[12] & lfsr_reg[8]) ^ (lfsr_reg[13] & lfsr_reg[20])
          ^ (nfsr_reg[95] & lfsr_reg[42]) ^ (lfsr_reg[60] & lfsr_reg[79])
          ^ (nfsr_reg[12] & nfsr_reg[95] & lfsr_reg[94])
          ^ lfsr_reg[93] ^ nfsr_reg[2] ^ nfsr_reg[15] ^ nfsr_reg[36] ^ nfsr_reg[45]
          ^ nfsr_reg[64] ^ nfsr_reg[73] ^ nfsr_reg[89];
        lf = lfsr_reg[0] ^ lfsr_reg[7] ^ lfsr_reg[38] ^ lfsr_reg[70]
           ^ lfsr_reg[81] ^ lfsr_reg[96];
        nf = lfsr_reg[0] ^ nfsr_reg[0] ^ nfsr_reg[26] ^ nfsr_reg[56] ^ nfsr_reg[91]
           ^ nfsr_reg[96]
           ^ (nfsr_reg[3] & nfsr_reg[67]) ^ (nfsr_reg[11] & nfsr_reg[13])
           ^ (nfsr_reg[17] & nfsr_reg[18]) ^ (nfsr_reg[27] & nfsr_reg[59])
           ^ (nfsr_reg[40] & nfsr_reg[48]) ^ (nfsr_reg[61] & nfsr_reg[65])
           ^ (nfsr_reg[68] & nfsr_reg[84])
           ^ (nfsr_reg[22] & nfsr_reg[24] & nfsr_reg[25])
           ^ (nfsr_reg[70] & nfsr_reg[78] & nfsr_reg[82])
           ^ (nfsr_reg[88] & nfsr_reg[92] & nfsr_reg[93] & nfsr_reg[95]);
    end

    // During initialization the pre-output is fed back into both registers.
    assign feed     = cmd.init_step & z;
    assign new_byte = {byte_shift_reg[BYTE_W-2:0], z};

    always_comb
    begin
        nfsr_next        = nfsr_reg;
        lfsr_next        = lfsr_reg;
        byte_shift_next  = byte_shift_reg;
        check_index_next = check_index_reg;
        mismatch_next    = mismatch_reg;
        if (cmd.load)
        begin
            nfsr_next        = {key_high, key_low};
            lfsr_next        = {1'b0, {31{1'b1}}, iv_high_reg, iv_low_reg};
            byte_shift_next  = '0;
            check_index_next = '0;
            mismatch_next    = 1'b0;
        end
        else if (cmd.init_step || cmd.stream_step)
        begin
            nfsr_next = {nf ^ feed, nfsr_reg[REG_LEN-1:1]};
            lfsr_next = {lf ^ feed, lfsr_reg[REG_LEN-1:1]};
        end
        if (cmd.stream_step)
        begin
            byte_shift_next = new_byte;
            if (cmd.byte_end && pending && (check_offset == byte_offset))
            begin
                if (cur_check[BYTE_W-1:0] != new_byte)
                begin
                    mismatch_next = 1'b1;
                end
                check_index_next = check_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nfsr_reg <= nfsr_next;
        lfsr_reg <= lfsr_next;
        if (cmd.capture)
        begin
            result_reg <= !mismatch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_shift_reg  <= '0;
            check_index_reg <= '0;
            mismatch_reg    <= 1'b0;
        end
        else
        begin
            byte_shift_reg  <= byte_shift_next;
            check_index_reg <= check_index_next;
            mismatch_reg    <= mismatch_next;
        end
    end

    assign key_passes = result_reg;

endmodule

// ----- rtl/grain128a_key_filter_unit.sv -----
// Top level of the Grain-128a candidate key filter.
//
//  channel      dir  payload                       handshake
//  key_in       in   key_low[63:0], key_high[63:0] valid/ready
//  result_out   out  key_passes                    valid/ready
//  cfg          in   index[2:0], data[63:0]        valid/ready (ready always high)
//
// One key goes through a load, the initialization rounds and the keystream bits of
// 2**OFFSET_BITS bytes, one cipher clock per cycle, then the result hand-off.
// Reset clears the sequencer, the configuration registers and the result valid.
// A stalled result holds in its register while the next key is taken; a key
// that finishes while the previous word still waits holds until that word goes.
module grain128a_key_filter_unit
    import g128kf_pkg::*;
#(
    parameter int MAX_CHECKS  = DEFAULT_MAX_CHECKS,
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
)
(
    input logic              clk,
    input logic              rst_n,
    g128kf_key_if.sink       key_in,
    g128kf_result_if.source  result_out,
    g128kf_cfg_if.sink       cfg
);

    dp_cmd_t                cmd;
    logic [OFFSET_BITS-1:0] byte_offset;

    assign cfg.ready = 1'b1;

    g128kf_ctrl #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (key_in.valid),
        .in_ready    (key_in.ready),
        .out_valid   (result_out.valid),
        .out_ready   (result_out.ready),
        .cmd         (cmd),
        .byte_offset (byte_offset)
    );

    g128kf_datapath #(
        .MAX_CHECKS  (MAX_CHECKS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .byte_offset (byte_offset),
        .key_low     (key_in.key_low),
        .key_high    (key_in.key_high),
        .cfg_write   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .key_passes  (result_out.key_passes)
    );

endmodule

// ----- rtl/g128kf_checker.sv -----
// Port-level checker for the key filter unit and its bind.
`include "grain128a_key_filter_unit_macros.svh"

module g128kf_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic key_passes,
    input logic cfg_valid,
    input logic cfg_ready
);

    // A stalled result word keeps its value.
    `G128KF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_passes))

    // Once a key is taken the input is no longer ready.
    `G128KF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // A new result appears together with the input opening again.
    `G128KF_ASSERT_SAME(a_done_frees_input, $rose(out_valid), in_ready)

    // The configuration port never stalls.
    `G128KF_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind grain128a_key_filter_unit g128kf_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (key_in.valid),
    .in_ready   (key_in.ready),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .key_passes (result_out.key_passes),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready)
);
